// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define TFTP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tftp header parser assertion failed");

// checked at every edge, reset included
`define TFTP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tftp header parser assertion failed");

`endif

// ===== hw/rtl/tftp_hp_pkg.sv =====
package tftp_hp_pkg;

  localparam int STRING_LIMIT = 128;
  localparam int CNT_W = $clog2(STRING_LIMIT);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_SERVICE_PORT = '0;
  localparam logic [15:0] SERVICE_PORT_RESET = 16'd69;

  localparam logic [15:0] OPC_FIRST = 16'd1;
  localparam logic [15:0] OPC_WRQ = 16'd2;
  localparam logic [15:0] OPC_DATA = 16'd3;
  localparam logic [15:0] OPC_ERROR = 16'd5;
  localparam logic [15:0] OPC_LAST = 16'd6;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_DISCARD = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  localparam logic [1:0] SID_FILENAME = 2'd0;
  localparam logic [1:0] SID_MODE = 2'd1;
  localparam logic [1:0] SID_ERRMSG = 2'd2;

  localparam logic [1:0] VERDICT_NONE = 2'd0;
  localparam logic [1:0] VERDICT_LOW = 2'd1;
  localparam logic [1:0] VERDICT_HIGH = 2'd2;

  localparam logic [7:0] CHAR_SUBST = 8'h2E;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_FIRST  = 4'b0010,
    PH_MODE   = 4'b0100,
    PH_REST   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        end_of_packet;
    logic [15:0] dest_port;
    logic        is_udp;
  } in_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [1:0]  string_id;
    logic [7:0]  char_value;
    logic [15:0] opcode_value;
    logic        opcode_known;
    logic [15:0] block_or_code;
    logic [15:0] data_bytes;
    logic        too_short;
    logic [1:0]  detect_verdict;
    logic        last_of_run;
  } out_t;

  // what one byte leaves for the back end: an optional string item and an
  // optional summary
  typedef struct packed {
    logic        str_valid;
    logic [1:0]  str_kind;
    logic [1:0]  string_id;
    logic [7:0]  char_value;
    logic        sum_valid;
    logic [15:0] opcode_value;
    logic        opcode_known;
    logic [15:0] block_or_code;
    logic [15:0] data_bytes;
    logic        too_short;
    logic [1:0]  detect_verdict;
  } act_t;

endpackage

// ===== hw/rtl/tftp_hp_front.sv =====
`include "assert_macros.svh"

module tftp_hp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tftp_hp_pkg::in_t   in_data,
  input  logic [15:0]        service_port,
  input  logic               q_full,
  output logic               push,
  output tftp_hp_pkg::act_t  push_data
);

  logic [15:0] byte_position, byte_position_next;
  logic [15:0] opcode_reg, opcode_reg_next;
  logic [15:0] number_reg, number_reg_next;
  tftp_hp_pkg::phase_t parse_phase, parse_phase_next;
  logic [tftp_hp_pkg::CNT_W-1:0] char_count, char_count_next;
  logic port_matched, port_matched_next;
  logic udp_seen, udp_seen_next;

  logic accept;
  logic [7:0] b;
  logic [1:0] sid;
  logic [16:0] len_inc;
  logic [15:0] len;
  logic shortp;
  logic known;
  tftp_hp_pkg::act_t act;

  assign in_ready = !q_full;
  assign accept = in_valid && !q_full;
  assign b = in_data.payload_byte;

  always_comb begin
    byte_position_next = byte_position;
    opcode_reg_next = opcode_reg;
    number_reg_next = number_reg;
    parse_phase_next = parse_phase;
    char_count_next = char_count;
    port_matched_next = port_matched;
    udp_seen_next = udp_seen;
    act = '0;
    sid = (parse_phase == tftp_hp_pkg::PH_MODE) ? tftp_hp_pkg::SID_MODE :
          (opcode_reg == tftp_hp_pkg::OPC_ERROR) ? tftp_hp_pkg::SID_ERRMSG :
          tftp_hp_pkg::SID_FILENAME;

    if (byte_position == 16'd0) begin
      port_matched_next = (in_data.dest_port == service_port);
      udp_seen_next = in_data.is_udp;
    end

    case (parse_phase)
      tftp_hp_pkg::PH_HEADER: begin
        if (byte_position == 16'd0) begin
          opcode_reg_next = {b, 8'h00};
        end else if (byte_position == 16'd1) begin
          opcode_reg_next = {opcode_reg[15:8], b};
          if (opcode_reg_next == tftp_hp_pkg::OPC_FIRST ||
              opcode_reg_next == tftp_hp_pkg::OPC_WRQ) begin
            parse_phase_next = tftp_hp_pkg::PH_FIRST;
            char_count_next = '0;
          end
        end else if (byte_position == 16'd2) begin
          number_reg_next = {b, 8'h00};
        end else if (byte_position == 16'd3) begin
          number_reg_next = {number_reg[15:8], b};
          if (opcode_reg == tftp_hp_pkg::OPC_ERROR) begin
            parse_phase_next = tftp_hp_pkg::PH_FIRST;
            char_count_next = '0;
          end
        end
      end
      tftp_hp_pkg::PH_FIRST, tftp_hp_pkg::PH_MODE: begin
        act.string_id = sid;
        if (b == 8'h00) begin
          act.str_valid = 1'b1;
          act.str_kind = tftp_hp_pkg::KIND_COMPLETE;
          if (parse_phase == tftp_hp_pkg::PH_FIRST &&
              opcode_reg != tftp_hp_pkg::OPC_ERROR) begin
            parse_phase_next = tftp_hp_pkg::PH_MODE;
            char_count_next = '0;
          end else begin
            parse_phase_next = tftp_hp_pkg::PH_REST;
          end
        end else if (in_data.end_of_packet) begin
          act.str_valid = 1'b1;
          act.str_kind = tftp_hp_pkg::KIND_DISCARD;
        end else if (char_count < tftp_hp_pkg::CNT_W'(tftp_hp_pkg::STRING_LIMIT - 1)) begin
          act.str_valid = 1'b1;
          act.str_kind = tftp_hp_pkg::KIND_CHAR;
          act.char_value = (b inside {[8'h20:8'h7E]}) ? b : tftp_hp_pkg::CHAR_SUBST;
          char_count_next = char_count + 1'b1;
        end
      end
      default: begin
      end
    endcase

    // summary uses the state as updated by this byte
    len_inc = {1'b0, byte_position} + 17'd1;
    len = (byte_position == 16'hFFFF) ? 16'hFFFF : len_inc[15:0];
    shortp = (len < 16'd4);
    known = (opcode_reg_next inside {[tftp_hp_pkg::OPC_FIRST:tftp_hp_pkg::OPC_LAST]});

    if (in_data.end_of_packet) begin
      act.sum_valid = 1'b1;
      act.opcode_value = opcode_reg_next;
      act.opcode_known = known;
      act.too_short = shortp;
      act.block_or_code =
        (!shortp && (opcode_reg_next inside {[tftp_hp_pkg::OPC_DATA:tftp_hp_pkg::OPC_ERROR]}))
        ? number_reg_next : 16'd0;
      act.data_bytes = (!shortp && opcode_reg_next == tftp_hp_pkg::OPC_DATA) ?
                       (len - 16'd4) : 16'd0;
      act.detect_verdict = (udp_seen_next && !shortp && known) ?
        (port_matched_next ? tftp_hp_pkg::VERDICT_HIGH : tftp_hp_pkg::VERDICT_LOW) :
        tftp_hp_pkg::VERDICT_NONE;
      byte_position_next = 16'd0;
      opcode_reg_next = 16'd0;
      number_reg_next = 16'd0;
      parse_phase_next = tftp_hp_pkg::PH_HEADER;
      char_count_next = '0;
    end else if (byte_position != 16'hFFFF) begin
      byte_position_next = byte_position + 16'd1;
    end
  end

  assign push = accept && (act.str_valid || act.sum_valid);
  assign push_data = act;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 16'd0;
      opcode_reg <= 16'd0;
      number_reg <= 16'd0;
      parse_phase <= tftp_hp_pkg::PH_HEADER;
      char_count <= '0;
      port_matched <= 1'b0;
      udp_seen <= 1'b0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      opcode_reg <= opcode_reg_next;
      number_reg <= number_reg_next;
      parse_phase <= parse_phase_next;
      char_count <= char_count_next;
      port_matched <= port_matched_next;
      udp_seen <= udp_seen_next;
    end
  end

  // every packet restarts from a clean header state
  `TFTP_ASSERT(a_eop_clears, accept && in_data.end_of_packet |=>
    byte_position == 16'd0 && parse_phase == tftp_hp_pkg::PH_HEADER)

endmodule

// ===== hw/rtl/tftp_hp_fifo.sv =====
`include "assert_macros.svh"

module tftp_hp_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tftp_hp_pkg::act_t  push_data,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output tftp_hp_pkg::act_t  head
);

  tftp_hp_pkg::act_t mem [tftp_hp_pkg::Q_DEPTH];
  logic [tftp_hp_pkg::Q_PTR_W-1:0] wptr, rptr;
  logic [tftp_hp_pkg::Q_CNT_W-1:0] count;

  localparam logic [tftp_hp_pkg::Q_PTR_W-1:0] PTR_LAST =
    tftp_hp_pkg::Q_PTR_W'(tftp_hp_pkg::Q_DEPTH - 1);
  localparam logic [tftp_hp_pkg::Q_CNT_W-1:0] CNT_FULL =
    tftp_hp_pkg::Q_CNT_W'(tftp_hp_pkg::Q_DEPTH);

  assign full = (count == CNT_FULL);
  assign empty = (count == '0);
  assign head = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TFTP_ASSERT_ALWAYS(a_count_bound, rst || count <= CNT_FULL)
  `TFTP_ASSERT(a_no_pop_empty, pop |-> !empty)

endmodule

// ===== hw/rtl/tftp_hp_back.sv =====
`include "assert_macros.svh"

module tftp_hp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  tftp_hp_pkg::act_t  head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output tftp_hp_pkg::out_t  out_data
);

  // set once the string item of the head entry has gone and its summary waits
  logic str_done;
  logic show_str;
  logic taken;

  assign out_valid = !empty;
  assign show_str = head.str_valid && !str_done;
  assign taken = out_valid && out_ready;
  assign pop = taken && !(show_str && head.sum_valid);

  always_comb begin
    out_data = '0;
    if (show_str) begin
      out_data.item_kind = head.str_kind;
      out_data.string_id = head.string_id;
      out_data.char_value = head.char_value;
      out_data.last_of_run = !head.sum_valid;
    end else begin
      out_data.item_kind = tftp_hp_pkg::KIND_SUMMARY;
      out_data.opcode_value = head.opcode_value;
      out_data.opcode_known = head.opcode_known;
      out_data.block_or_code = head.block_or_code;
      out_data.data_bytes = head.data_bytes;
      out_data.too_short = head.too_short;
      out_data.detect_verdict = head.detect_verdict;
      out_data.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      str_done <= 1'b0;
    end else if (taken) begin
      str_done <= show_str && head.sum_valid;
    end
  end

  `TFTP_ASSERT(a_split_entry, str_done |-> !empty && head.str_valid && head.sum_valid)

endmodule

// ===== hw/rtl/tftp_header_parser_top.sv =====
// TFTP header parser: takes one UDP payload byte per cycle while in_ready is
// high and returns string characters, string complete/discard marks and a
// per-packet summary. The front end accepts a byte every cycle as long as the
// four-entry result queue has room; a byte's result is registered in the
// queue before it reaches the output. A byte that ends a packet inside a
// string yields two results, string item before summary; the queue absorbs
// them. service_port sits at address 0 of the config port.
module tftp_header_parser_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tftp_hp_pkg::in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tftp_hp_pkg::out_t              out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tftp_hp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [15:0] service_port;
  logic reg_hit;
  logic q_full, q_empty, q_push, q_pop;
  tftp_hp_pkg::act_t q_in, q_head;

  assign pready = 1'b1;
  assign reg_hit = (paddr[tftp_hp_pkg::ADDR_W-1:2] == tftp_hp_pkg::REG_SERVICE_PORT);
  assign prdata = reg_hit ? {16'h0000, service_port} : 32'h0000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      service_port <= tftp_hp_pkg::SERVICE_PORT_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      service_port <= pwdata[15:0];
    end
  end

  tftp_hp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .service_port (service_port),
    .q_full       (q_full),
    .push         (q_push),
    .push_data    (q_in)
  );

  tftp_hp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  tftp_hp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
